### src/arpc_pkg.sv
// Shared types and constants for the ARP cache responder.
package arpc_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP = CSR_IDX_W'(1);

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_RX = 2'd1;
   localparam logic [1:0] KIND_SEND_REQ = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   localparam logic [1:0] SEND_OP_NONE = 2'd0;
   localparam logic [1:0] SEND_OP_REQUEST = 2'd1;
   localparam logic [1:0] SEND_OP_REPLY = 2'd2;

   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] MIN_PKT_LEN = 16'd28;
   localparam logic [15:0] HTYPE_ETHERNET = 16'd1;
   localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
   localparam logic [7:0] HLEN_ETHERNET = 8'd6;
   localparam logic [7:0] PLEN_IPV4 = 8'd4;
   localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic commit;
   } arpc_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic rsp_free;
   } arpc_sts_type;

endpackage

### src/arpc_ctrl.sv
// Controller state machine: accept, table scan, drain, commit.
module arpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  arpc_pkg::arpc_sts_type sts,
   output arpc_pkg::arpc_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = sts.need_scan ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/arpc_dp.sv
// Datapath: request registers, entry table, scan compare and result register.
module arpc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  arpc_pkg::arpc_cmd_type              cmd,
   output arpc_pkg::arpc_sts_type              sts,
   input  logic                                rsp_ready,
   input  logic                                csr_valid,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [1:0]                          req_type,
   input  logic [31:0]                         req_ip_addr,
   input  logic [15:0]                         req_pkt_len,
   input  logic [15:0]                         req_htype,
   input  logic [15:0]                         req_ptype,
   input  logic [7:0]                          req_hlen,
   input  logic [7:0]                          req_plen,
   input  logic [15:0]                         req_opcode,
   input  logic [47:0]                         req_sender_mac,
   input  logic [31:0]                         req_sender_ip,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic [47:0]                         rsp_found_mac,
   output logic                                rsp_was_update,
   output logic                                rsp_len_warning,
   output logic                                rsp_send_valid,
   output logic [1:0]                          rsp_send_opcode,
   output logic [47:0]                         rsp_send_dest_mac,
   output logic [31:0]                         rsp_send_dest_ip
);

   localparam int N = arpc_pkg::TABLE_ENTRIES;
   localparam int IW = arpc_pkg::IDX_W;

   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff;

   logic [1:0]  kind_ff;
   logic        short_ff, bad_ff, warn_ff, op_req_ff;
   logic [31:0] key_ff, dip_ff, sip_ff;
   logic [47:0] smac_ff;
   logic        is_short, is_bad;

   logic [N-1:0]  valid_ff;
   logic [31:0]   ip_mem [N];
   logic [47:0]   mac_mem [N];
   logic [31:0]   ip_q_ff;
   logic [47:0]   mac_q_ff;
   logic [IW-1:0] cnt_ff;
   logic          rd_vld_ff;
   logic [IW-1:0] rd_idx_ff;

   logic          hit_ff, free_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic [47:0]   hit_mac_ff;

   logic          wr_ip, wr_mac, set_valid;
   logic [IW-1:0] wr_idx;
   logic [1:0]    res_status, res_send_op;
   logic          res_found, res_update, res_warn, res_send;
   logic [47:0]   res_found_mac, res_dmac;
   logic [31:0]   res_dip;

   logic          rsp_valid_ff;
   logic [1:0]    status_ff, send_op_ff;
   logic          found_ff, update_ff, warn_out_ff, send_ff;
   logic [47:0]   found_mac_ff, dmac_ff;
   logic [31:0]   dip_out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == arpc_pkg::CSR_OWN_MAC) begin
            own_mac_ff <= csr_wdata;
         end else if (csr_index == arpc_pkg::CSR_OWN_IP) begin
            own_ip_ff <= csr_wdata[31:0];
         end
      end
   end

   assign is_short = req_pkt_len < arpc_pkg::MIN_PKT_LEN;
   assign is_bad = (req_htype != arpc_pkg::HTYPE_ETHERNET) ||
                   (req_ptype != arpc_pkg::PTYPE_IPV4);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_type;
         short_ff <= is_short;
         bad_ff <= is_bad;
         warn_ff <= (req_hlen != arpc_pkg::HLEN_ETHERNET) ||
                    (req_plen != arpc_pkg::PLEN_IPV4);
         op_req_ff <= req_opcode == arpc_pkg::ARP_OP_REQUEST;
         key_ff <= (req_type == arpc_pkg::KIND_LOOKUP) ? req_ip_addr : req_sender_ip;
         dip_ff <= req_ip_addr;
         sip_ff <= req_sender_ip;
         smac_ff <= req_sender_mac;
      end
   end

   assign sts.need_scan = (req_type == arpc_pkg::KIND_LOOKUP) ||
                          ((req_type == arpc_pkg::KIND_RX) && !is_short && !is_bad);
   assign sts.scan_last = cnt_ff == IW'(N - 1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   // scan counter and read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         if (cmd.load_req) begin
            cnt_ff <= '0;
         end else if (cmd.scan_step) begin
            cnt_ff <= cnt_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         ip_q_ff <= ip_mem[cnt_ff];
         mac_q_ff <= mac_mem[cnt_ff];
         rd_idx_ff <= cnt_ff;
      end
      if (wr_ip) begin
         ip_mem[wr_idx] <= sip_ff;
      end
      if (wr_mac) begin
         mac_mem[wr_idx] <= smac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (set_valid) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // hit and first free slot, tracked over the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.load_req) begin
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (valid_ff[rd_idx_ff] && (ip_q_ff == key_ff) && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!valid_ff[rd_idx_ff] && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && valid_ff[rd_idx_ff] && (ip_q_ff == key_ff) && !hit_ff) begin
         hit_idx_ff <= rd_idx_ff;
         hit_mac_ff <= mac_q_ff;
      end
      if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // result and table update
   always_comb begin
      res_status = arpc_pkg::STATUS_OK;
      res_found = 1'b0;
      res_found_mac = '0;
      res_update = 1'b0;
      res_warn = 1'b0;
      res_send = 1'b0;
      res_send_op = arpc_pkg::SEND_OP_NONE;
      res_dmac = '0;
      res_dip = '0;
      wr_ip = 1'b0;
      wr_mac = 1'b0;
      set_valid = 1'b0;
      wr_idx = hit_idx_ff;
      case (kind_ff)
         arpc_pkg::KIND_LOOKUP: begin
            res_found = hit_ff;
            res_found_mac = hit_ff ? hit_mac_ff : '0;
         end
         arpc_pkg::KIND_RX: begin
            if (short_ff) begin
               res_status = arpc_pkg::STATUS_SHORT;
            end else if (bad_ff) begin
               res_status = arpc_pkg::STATUS_BAD_TYPE;
            end else begin
               res_warn = warn_ff;
               if (hit_ff) begin
                  wr_mac = cmd.commit;
                  res_update = 1'b1;
               end else if (free_ff) begin
                  wr_idx = free_idx_ff;
                  wr_ip = cmd.commit;
                  wr_mac = cmd.commit;
                  set_valid = cmd.commit;
               end else begin
                  res_status = arpc_pkg::STATUS_FULL;
               end
               if ((hit_ff || free_ff) && op_req_ff) begin
                  res_send = 1'b1;
                  res_send_op = arpc_pkg::SEND_OP_REPLY;
                  res_dmac = smac_ff;
                  res_dip = sip_ff;
               end
            end
         end
         arpc_pkg::KIND_SEND_REQ: begin
            res_send = 1'b1;
            res_send_op = arpc_pkg::SEND_OP_REQUEST;
            res_dmac = arpc_pkg::BROADCAST_MAC;
            res_dip = dip_ff;
         end
         default: begin
            res_status = arpc_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= res_status;
         found_ff <= res_found;
         found_mac_ff <= res_found_mac;
         update_ff <= res_update;
         warn_out_ff <= res_warn;
         send_ff <= res_send;
         send_op_ff <= res_send_op;
         dmac_ff <= res_dmac;
         dip_out_ff <= res_dip;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_found_mac = found_mac_ff;
   assign rsp_was_update = update_ff;
   assign rsp_len_warning = warn_out_ff;
   assign rsp_send_valid = send_ff;
   assign rsp_send_opcode = send_op_ff;
   assign rsp_send_dest_mac = dmac_ff;
   assign rsp_send_dest_ip = dip_out_ff;

endmodule

### src/arp_cache_responder.sv
// ARP cache responder top level: controller, datapath and checks.
// Lookups and received packets that pass the length and type checks walk the
// 32-entry table through one memory read port, one entry per cycle, then pass
// a drain state; dropped packets, send-request and unknown kinds skip both. A
// held result delays the commit; the next transaction waits for the commit.
// Synchronous active-high reset clears all valid bits, the CSR registers, the
// scan counter and flags, rsp_valid and the control state; no clearing pass.
module arp_cache_responder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_req_type,
   input  logic [31:0]                        req_ip_addr,
   input  logic [15:0]                        req_pkt_len,
   input  logic [15:0]                        req_htype,
   input  logic [15:0]                        req_ptype,
   input  logic [7:0]                         req_hlen,
   input  logic [7:0]                         req_plen,
   input  logic [15:0]                        req_opcode,
   input  logic [47:0]                        req_sender_mac,
   input  logic [31:0]                        req_sender_ip,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_found,
   output logic [47:0]                        rsp_found_mac,
   output logic                               rsp_was_update,
   output logic                               rsp_len_warning,
   output logic                               rsp_send_valid,
   output logic [1:0]                         rsp_send_opcode,
   output logic [47:0]                        rsp_send_dest_mac,
   output logic [31:0]                        rsp_send_dest_ip
);

   arpc_pkg::arpc_cmd_type cmd;
   arpc_pkg::arpc_sts_type sts;

   assign csr_ready = 1'b1;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   arpc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ready),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_req_type),
      .req_ip_addr       (req_ip_addr),
      .req_pkt_len       (req_pkt_len),
      .req_htype         (req_htype),
      .req_ptype         (req_ptype),
      .req_hlen          (req_hlen),
      .req_plen          (req_plen),
      .req_opcode        (req_opcode),
      .req_sender_mac    (req_sender_mac),
      .req_sender_ip     (req_sender_ip),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_found_mac     (rsp_found_mac),
      .rsp_was_update    (rsp_was_update),
      .rsp_len_warning   (rsp_len_warning),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_send_opcode   (rsp_send_opcode),
      .rsp_send_dest_mac (rsp_send_dest_mac),
      .rsp_send_dest_ip  (rsp_send_dest_ip)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction while busy");

   a_found_is_lookup_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == arpc_pkg::STATUS_OK && !rsp_send_valid
         && !rsp_was_update && !rsp_len_warning))
      else $error("lookup hit mixed with packet fields");

   a_full_sends_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == arpc_pkg::STATUS_FULL) |-> (!rsp_send_valid && !rsp_was_update))
      else $error("table-full result sends or updates");

   a_send_opcode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_valid) |-> (rsp_send_opcode == arpc_pkg::SEND_OP_REQUEST
         || rsp_send_opcode == arpc_pkg::SEND_OP_REPLY))
      else $error("send without a valid opcode");

endmodule

### test/tb_arp_cache_responder.sv
// Self-checking testbench for arp_cache_responder: directed table, random traffic, scoreboard.
module tb_arp_cache_responder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [15:0] ARP_OP_REPLY = 16'd2;
   localparam logic [arpc_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE = arpc_pkg::CSR_OWN_IP + 1'b1;
   localparam logic [arpc_pkg::CSR_IDX_W-1:0] CSR_IDX_TOP = '1;
   localparam int POOL_SIZE = 48;
   localparam int LONG_HOLD_AT = 60;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] ip_addr;
      logic [15:0] pkt_len;
      logic [15:0] htype;
      logic [15:0] ptype;
      logic [7:0]  hlen;
      logic [7:0]  plen;
      logic [15:0] opcode;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
   } arp_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [47:0] found_mac;
      logic        was_update;
      logic        len_warning;
      logic        send_valid;
      logic [1:0]  send_opcode;
      logic [47:0] send_dest_mac;
      logic [31:0] send_dest_ip;
   } arp_rsp_type;

   typedef struct {
      arp_req_type req;
      bit          typed;
      arp_rsp_type rsp;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [arpc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [arpc_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                            req_valid;
   logic                            req_ready;
   logic [1:0]                      req_req_type;
   logic [31:0]                     req_ip_addr;
   logic [15:0]                     req_pkt_len;
   logic [15:0]                     req_htype;
   logic [15:0]                     req_ptype;
   logic [7:0]                      req_hlen;
   logic [7:0]                      req_plen;
   logic [15:0]                     req_opcode;
   logic [47:0]                     req_sender_mac;
   logic [31:0]                     req_sender_ip;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [1:0]                      rsp_status;
   logic                            rsp_found;
   logic [47:0]                     rsp_found_mac;
   logic                            rsp_was_update;
   logic                            rsp_len_warning;
   logic                            rsp_send_valid;
   logic [1:0]                      rsp_send_opcode;
   logic [47:0]                     rsp_send_dest_mac;
   logic [31:0]                     rsp_send_dest_ip;

   // shadow copy of the cache
   logic        cache_valid [arpc_pkg::TABLE_ENTRIES];
   logic [31:0] cache_ip    [arpc_pkg::TABLE_ENTRIES];
   logic [47:0] cache_mac   [arpc_pkg::TABLE_ENTRIES];

   arp_rsp_type  pending_rsp[$];
   stim_row_type directed_rows[$];
   logic [31:0]  ip_pool [POOL_SIZE];
   int           error_count = 0;
   int           rsp_count = 0;
   int           stall_left = 0;

   arp_cache_responder DUT (.*);

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [47:0] got,
                                input logic [47:0] want);
      if (got !== want)
         report_mismatch($sformatf("rsp #%0d %s: got %h, expected %h",
                                   rsp_count, name, got, want));
   endtask

   function automatic int find_slot(input logic [31:0] ip);
      for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++)
         if (cache_valid[i] && cache_ip[i] == ip) return i;
      return -1;
   endfunction

   // computes the response to one transaction and updates the shadow cache
   function automatic arp_rsp_type arp_resolve(input arp_req_type r);
      arp_rsp_type o;
      int          slot;
      o = '0;
      case (r.req_type)
         arpc_pkg::KIND_LOOKUP: begin
            slot = find_slot(r.ip_addr);
            if (slot >= 0) begin
               o.found = 1'b1;
               o.found_mac = cache_mac[slot];
            end
         end
         arpc_pkg::KIND_RX: begin
            if (r.pkt_len < arpc_pkg::MIN_PKT_LEN) begin
               o.status = arpc_pkg::STATUS_SHORT;
            end else if (r.htype != arpc_pkg::HTYPE_ETHERNET ||
                         r.ptype != arpc_pkg::PTYPE_IPV4) begin
               o.status = arpc_pkg::STATUS_BAD_TYPE;
            end else begin
               o.len_warning = (r.hlen != arpc_pkg::HLEN_ETHERNET) ||
                               (r.plen != arpc_pkg::PLEN_IPV4);
               slot = find_slot(r.sender_ip);
               if (slot >= 0) begin
                  cache_mac[slot] = r.sender_mac;
                  o.was_update = 1'b1;
               end else begin
                  for (int i = 0; i < arpc_pkg::TABLE_ENTRIES && slot < 0; i++)
                     if (!cache_valid[i]) slot = i;
                  if (slot < 0) begin
                     o.status = arpc_pkg::STATUS_FULL;
                  end else begin
                     cache_valid[slot] = 1'b1;
                     cache_ip[slot] = r.sender_ip;
                     cache_mac[slot] = r.sender_mac;
                  end
               end
               if (o.status == arpc_pkg::STATUS_OK &&
                   r.opcode == arpc_pkg::ARP_OP_REQUEST) begin
                  o.send_valid = 1'b1;
                  o.send_opcode = arpc_pkg::SEND_OP_REPLY;
                  o.send_dest_mac = r.sender_mac;
                  o.send_dest_ip = r.sender_ip;
               end
            end
         end
         arpc_pkg::KIND_SEND_REQ: begin
            o.send_valid = 1'b1;
            o.send_opcode = arpc_pkg::SEND_OP_REQUEST;
            o.send_dest_mac = arpc_pkg::BROADCAST_MAC;
            o.send_dest_ip = r.ip_addr;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic arp_req_type lookup_req(input logic [31:0] ip);
      arp_req_type r;
      r = '0;
      r.req_type = arpc_pkg::KIND_LOOKUP;
      r.ip_addr = ip;
      return r;
   endfunction

   function automatic arp_req_type send_req(input logic [31:0] ip);
      arp_req_type r;
      r = '0;
      r.req_type = arpc_pkg::KIND_SEND_REQ;
      r.ip_addr = ip;
      return r;
   endfunction

   function automatic arp_req_type rx_pkt(input logic [15:0] len, input logic [15:0] ht,
                                          input logic [15:0] pt, input logic [7:0] hl,
                                          input logic [7:0] pl, input logic [15:0] op,
                                          input logic [47:0] smac, input logic [31:0] sip);
      arp_req_type r;
      r = '0;
      r.req_type = arpc_pkg::KIND_RX;
      r.pkt_len = len;
      r.htype = ht;
      r.ptype = pt;
      r.hlen = hl;
      r.plen = pl;
      r.opcode = op;
      r.sender_mac = smac;
      r.sender_ip = sip;
      return r;
   endfunction

   function automatic arp_rsp_type fixed_rsp(input logic [1:0] st, input logic [1:0] op,
                                             input logic [47:0] dmac,
                                             input logic [31:0] dip);
      arp_rsp_type o;
      o = '0;
      o.status = st;
      o.send_valid = (op != arpc_pkg::SEND_OP_NONE);
      o.send_opcode = op;
      o.send_dest_mac = dmac;
      o.send_dest_ip = dip;
      return o;
   endfunction

   function automatic arp_req_type random_item(input int pool_hi);
      arp_req_type r;
      int          pick;
      r.req_type = 2'($urandom);
      r.ip_addr = $urandom;
      r.pkt_len = 16'($urandom);
      r.htype = 16'($urandom);
      r.ptype = 16'($urandom);
      r.hlen = 8'($urandom);
      r.plen = 8'($urandom);
      r.opcode = 16'($urandom);
      r.sender_mac = 48'({$urandom, $urandom});
      r.sender_ip = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.req_type = arpc_pkg::KIND_LOOKUP;
         if (pick < 25) r.ip_addr = ip_pool[$urandom_range(0, pool_hi)];
      end else if (pick < 75) begin
         r.req_type = arpc_pkg::KIND_RX;
         if ($urandom_range(0, 3) == 0) r.pkt_len = 16'($urandom_range(28, 65535));
         else r.pkt_len = 16'($urandom_range(28, 64));
         r.htype = arpc_pkg::HTYPE_ETHERNET;
         r.ptype = arpc_pkg::PTYPE_IPV4;
         if ($urandom_range(0, 9) != 0) begin
            r.hlen = arpc_pkg::HLEN_ETHERNET;
            r.plen = arpc_pkg::PLEN_IPV4;
         end
         if ($urandom_range(0, 9) != 0) r.opcode = 16'($urandom_range(1, 2));
         r.sender_ip = ip_pool[$urandom_range(0, pool_hi)];
      end else if (pick < 85) begin
         r.req_type = arpc_pkg::KIND_SEND_REQ;
      end else if (pick < 95) begin
         // malformed packet: short, or one of the two type fields wrong
         r.req_type = arpc_pkg::KIND_RX;
         if ($urandom_range(0, 1)) r.pkt_len = 16'($urandom_range(0, 27));
         else if ($urandom_range(0, 1)) r.htype = arpc_pkg::HTYPE_ETHERNET;
         else r.ptype = arpc_pkg::PTYPE_IPV4;
      end else begin
         r.req_type = KIND_UNKNOWN;
      end
      return r;
   endfunction

   task automatic check_response();
      arp_rsp_type want;
      rsp_count++;
      if (pending_rsp.size() == 0) begin
         report_mismatch($sformatf("rsp #%0d with no transaction outstanding", rsp_count));
      end else begin
         want = pending_rsp.pop_front();
         compare_field("status", 48'(rsp_status), 48'(want.status));
         compare_field("found", 48'(rsp_found), 48'(want.found));
         compare_field("found_mac", rsp_found_mac, want.found_mac);
         compare_field("was_update", 48'(rsp_was_update), 48'(want.was_update));
         compare_field("len_warning", 48'(rsp_len_warning), 48'(want.len_warning));
         compare_field("send_valid", 48'(rsp_send_valid), 48'(want.send_valid));
         compare_field("send_opcode", 48'(rsp_send_opcode), 48'(want.send_opcode));
         compare_field("send_dest_mac", rsp_send_dest_mac, want.send_dest_mac);
         compare_field("send_dest_ip", 48'(rsp_send_dest_ip), 48'(want.send_dest_ip));
      end
   endtask

   // response side: random backpressure plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_response();
            if (rsp_count == LONG_HOLD_AT) stall_left = LONG_HOLD_CYCLES;
            else stall_left = pick_gap((rsp_count % 100) >= 40 && (rsp_count % 100) < 60);
         end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = pick_gap(1'b0);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [arpc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [47:0] mac, input logic [31:0] ip,
                             input logic [arpc_pkg::CSR_IDX_W-1:0] spare_idx,
                             input logic [47:0] spare_data);
      write_reg(arpc_pkg::CSR_OWN_MAC, mac);
      write_reg(arpc_pkg::CSR_OWN_IP, 48'(ip));
      write_reg(spare_idx, spare_data);
      csr_valid <= 1'b0;
   endtask

   task automatic drive_item(input arp_req_type r, input bit typed,
                             input arp_rsp_type fixed, input int gap);
      arp_rsp_type want;
      req_valid <= 1'b1;
      req_req_type <= r.req_type;
      req_ip_addr <= r.ip_addr;
      req_pkt_len <= r.pkt_len;
      req_htype <= r.htype;
      req_ptype <= r.ptype;
      req_hlen <= r.hlen;
      req_plen <= r.plen;
      req_opcode <= r.opcode;
      req_sender_mac <= r.sender_mac;
      req_sender_ip <= r.sender_ip;
      do @(posedge clock); while (!req_ready);
      want = arp_resolve(r);
      pending_rsp.push_back(typed ? fixed : want);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int pool_hi);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2 && pool_hi == POOL_SIZE - 1) wait_drained();
         drive_item(random_item(pool_hi), 1'b0, '0, pick_gap((n % 100) < 20));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_req_type = '0;
      req_ip_addr = '0;
      req_pkt_len = '0;
      req_htype = '0;
      req_ptype = '0;
      req_hlen = '0;
      req_plen = '0;
      req_opcode = '0;
      req_sender_mac = '0;
      req_sender_ip = '0;
      foreach (cache_valid[i]) cache_valid[i] = 1'b0;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

      directed_rows.push_back('{lookup_req('0), 1'b1, '0});
      directed_rows.push_back('{lookup_req('1), 1'b1, '0});
      directed_rows.push_back('{rx_pkt(16'd0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_SHORT, arpc_pkg::SEND_OP_NONE,
                                          '0, '0)});
      directed_rows.push_back('{rx_pkt(16'd27, arpc_pkg::HTYPE_ETHERNET, arpc_pkg::PTYPE_IPV4,
                                       arpc_pkg::HLEN_ETHERNET, arpc_pkg::PLEN_IPV4,
                                       arpc_pkg::ARP_OP_REQUEST, 48'h1, 32'h1), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_SHORT, arpc_pkg::SEND_OP_NONE,
                                          '0, '0)});
      directed_rows.push_back('{rx_pkt(arpc_pkg::MIN_PKT_LEN, '0, arpc_pkg::PTYPE_IPV4,
                                       arpc_pkg::HLEN_ETHERNET, arpc_pkg::PLEN_IPV4,
                                       arpc_pkg::ARP_OP_REQUEST, 48'h2, 32'h2), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_BAD_TYPE, arpc_pkg::SEND_OP_NONE,
                                          '0, '0)});
      directed_rows.push_back('{rx_pkt('1, arpc_pkg::HTYPE_ETHERNET, '1, '0, '0,
                                       arpc_pkg::ARP_OP_REQUEST, 48'h3, 32'h3), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_BAD_TYPE, arpc_pkg::SEND_OP_NONE,
                                          '0, '0)});
      directed_rows.push_back('{rx_pkt('1, '1, '0, '1, '1, '1, '1, '1), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_BAD_TYPE, arpc_pkg::SEND_OP_NONE,
                                          '0, '0)});
      directed_rows.push_back('{rx_pkt(arpc_pkg::MIN_PKT_LEN, arpc_pkg::HTYPE_ETHERNET,
                                       arpc_pkg::PTYPE_IPV4, arpc_pkg::HLEN_ETHERNET,
                                       arpc_pkg::PLEN_IPV4, arpc_pkg::ARP_OP_REQUEST,
                                       '0, '0), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_OK, arpc_pkg::SEND_OP_REPLY,
                                          '0, '0)});
      directed_rows.push_back('{rx_pkt('1, arpc_pkg::HTYPE_ETHERNET, arpc_pkg::PTYPE_IPV4,
                                       arpc_pkg::HLEN_ETHERNET, arpc_pkg::PLEN_IPV4,
                                       ARP_OP_REPLY, '1, '1), 1'b1, '0});
      directed_rows.push_back('{rx_pkt(16'd60, arpc_pkg::HTYPE_ETHERNET, arpc_pkg::PTYPE_IPV4,
                                       '0, '1, arpc_pkg::ARP_OP_REQUEST,
                                       48'h0200_0000_0001, '0), 1'b0, '0});
      directed_rows.push_back('{rx_pkt(16'd42, arpc_pkg::HTYPE_ETHERNET, arpc_pkg::PTYPE_IPV4,
                                       '1, '0, '1, 48'h8000_0000_0000, '1), 1'b0, '0});
      directed_rows.push_back('{rx_pkt(16'd28, arpc_pkg::HTYPE_ETHERNET, arpc_pkg::PTYPE_IPV4,
                                       arpc_pkg::HLEN_ETHERNET, arpc_pkg::PLEN_IPV4, '0,
                                       48'h0A0B_0C0D_0E0F, 32'hC0A8_0001), 1'b0, '0});
      directed_rows.push_back('{lookup_req('0), 1'b0, '0});
      directed_rows.push_back('{lookup_req('1), 1'b0, '0});
      directed_rows.push_back('{lookup_req(32'hC0A8_0001), 1'b0, '0});
      directed_rows.push_back('{lookup_req(32'h0A00_0001), 1'b1, '0});
      directed_rows.push_back('{send_req('0), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_OK, arpc_pkg::SEND_OP_REQUEST,
                                          arpc_pkg::BROADCAST_MAC, '0)});
      directed_rows.push_back('{send_req('1), 1'b1,
                                fixed_rsp(arpc_pkg::STATUS_OK, arpc_pkg::SEND_OP_REQUEST,
                                          arpc_pkg::BROADCAST_MAC, '1)});
      directed_rows.push_back('{'1, 1'b1, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config('1, '0, CSR_IDX_SPARE, '1);
      foreach (directed_rows[i])
         drive_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp,
                    pick_gap(1'b0));
      wait_drained();

      // few distinct senders first, then enough of them to fill the cache
      set_config('0, '1, CSR_IDX_TOP, '0);
      run_random(150, POOL_SIZE / 2 - 1);
      wait_drained();

      set_config(48'({$urandom, $urandom}), $urandom, CSR_IDX_TOP, 48'({$urandom, $urandom}));
      run_random(250, POOL_SIZE - 1);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
